>>> hdl/tklm_pkg.sv
package tklm_pkg;

    localparam int MAX_KEEP   = 64;
    localparam int MAX_VECTOR = 65536;

    localparam int LOGIT_W = 32;
    localparam int KEEP_W  = 7;
    // One bit above the vector length so that the counter can saturate.
    localparam int SEEN_W  = $clog2(MAX_VECTOR) + 1;

    // The threshold is picked from the cells through a two-level registered tree.
    localparam int GRP_SIZE = 8;
    localparam int LANE_W   = $clog2(GRP_SIZE);
    localparam int NUM_GRP  = (MAX_KEEP + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int SEL_W    = GRP_W + LANE_W;

    typedef logic signed [LOGIT_W-1:0] t_logit;

    localparam t_logit NEG_INF = {1'b1, {(LOGIT_W-1){1'b0}}};

    localparam logic KIND_SCAN  = 1'b0;
    localparam logic KIND_APPLY = 1'b1;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_PICK,
        ST_SET
    } t_state;

    typedef struct packed {
        logic             insert;
        logic             clear;
        logic             pick;
        logic [SEL_W-1:0] sel;
    } t_list_ctrl;

endpackage

>>> hdl/tklm_cell.sv
module tklm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_insert,
    input  logic            i_clear,
    input  tklm_pkg::t_logit i_value,
    input  tklm_pkg::t_logit i_left_value,
    input  logic            i_left_lt,
    output tklm_pkg::t_logit o_value,
    output logic            o_lt
);
    import tklm_pkg::*;

    t_logit r_value;
    t_logit n_value;

    // The list is descending, so the cells below the new value form a
    // contiguous tail; the first of them takes the value, the rest shift.
    assign o_lt    = r_value < i_value;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_clear) begin
            n_value = NEG_INF;
        end else if (i_insert && o_lt) begin
            n_value = i_left_lt ? i_left_value : i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= NEG_INF;
        end else begin
            r_value <= n_value;
        end
    end

endmodule

>>> hdl/tklm_list.sv
module tklm_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tklm_pkg::t_list_ctrl i_ctrl,
    input  tklm_pkg::t_logit    i_value,
    output tklm_pkg::t_logit    o_pick
);
    import tklm_pkg::*;

    t_logit cell_val [MAX_KEEP];
    logic   cell_lt  [MAX_KEEP];
    t_logit lane_val [NUM_GRP][GRP_SIZE];
    t_logit r_grp    [NUM_GRP];

    logic [LANE_W-1:0] lane;
    logic [GRP_W-1:0]  grp;

    assign lane = i_ctrl.sel[LANE_W-1:0];
    assign grp  = i_ctrl.sel[SEL_W-1:LANE_W];

    genvar i, g, l;
    generate
        for (i = 0; i < MAX_KEEP; i++) begin : g_cell
            if (i == 0) begin : g_head
                tklm_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_insert     (i_ctrl.insert),
                    .i_clear      (i_ctrl.clear),
                    .i_value      (i_value),
                    .i_left_value (NEG_INF),
                    .i_left_lt    (1'b0),
                    .o_value      (cell_val[i]),
                    .o_lt         (cell_lt[i])
                );
            end else begin : g_body
                tklm_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_insert     (i_ctrl.insert),
                    .i_clear      (i_ctrl.clear),
                    .i_value      (i_value),
                    .i_left_value (cell_val[i-1]),
                    .i_left_lt    (cell_lt[i-1]),
                    .o_value      (cell_val[i]),
                    .o_lt         (cell_lt[i])
                );
            end
        end

        for (g = 0; g < NUM_GRP; g++) begin : g_grp
            for (l = 0; l < GRP_SIZE; l++) begin : g_lane
                if (g * GRP_SIZE + l < MAX_KEEP) begin : g_used
                    assign lane_val[g][l] = cell_val[g * GRP_SIZE + l];
                end else begin : g_pad
                    assign lane_val[g][l] = NEG_INF;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ctrl.pick) begin
                    r_grp[g] <= lane_val[g][lane];
                end
            end
        end
    endgenerate

    assign o_pick = r_grp[grp];

endmodule

>>> hdl/top_k_logit_mask_unit.sv
// Apply request: result is registered, valid in the cycle after acceptance.
// Throughput: one request per cycle in both passes while the output is not stalled.
// A scan request marked last inserts its value, then the input stalls in ST_PICK and
// ST_SET while the threshold is picked from the cell row and the row is cleared.
// Reset (synchronous, active low) clears the cell row to minus infinity, the
// element count, keep_count and the threshold; masking starts off.
module top_k_logit_mask_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tklm_pkg::KEEP_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic signed [tklm_pkg::LOGIT_W-1:0] i_logit,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [tklm_pkg::LOGIT_W-1:0] o_logit_out,
    output logic                          o_last_out
);
    import tklm_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [KEEP_W-1:0] r_keep_count;
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic [SEEN_W-1:0] seen_inc;
    logic [SEEN_W-1:0] k_ext;
    logic [SEEN_W-1:0] k_sat;
    logic [SEL_W-1:0]  r_sel;
    logic              r_mask_pend;
    logic              r_mask_active;
    t_logit            r_threshold;
    t_logit            pick;

    logic   r_out_valid;
    t_logit r_logit_out;
    logic   r_last_out;

    logic       in_acc;
    logic       scan_acc;
    logic       apply_acc;
    logic       out_free;
    t_list_ctrl list_ctrl;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_SCAN) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign scan_acc   = in_acc && (i_kind == KIND_SCAN);
    assign apply_acc  = in_acc && (i_kind == KIND_APPLY);

    assign seen_inc = (r_seen == SEEN_MAX) ? r_seen : r_seen + SEEN_W'(1);
    assign k_ext    = SEEN_W'(r_keep_count);
    assign k_sat    = (k_ext > SEEN_W'(MAX_KEEP)) ? SEEN_W'(MAX_KEEP) : k_ext;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SCAN: begin
                if (scan_acc && i_last) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: n_state = ST_SET;
            ST_SET:  n_state = ST_SCAN;
            default: n_state = ST_SCAN;
        endcase
    end

    always_comb begin
        list_ctrl.insert = 1'b0;
        list_ctrl.clear  = 1'b0;
        list_ctrl.pick   = 1'b0;
        list_ctrl.sel    = r_sel;
        n_seen           = r_seen;
        case (r_state)
            ST_SCAN: begin
                list_ctrl.insert = scan_acc;
                if (scan_acc) begin
                    n_seen = seen_inc;
                end
            end
            ST_PICK: begin
                // The group registers take the old cell values at this edge.
                list_ctrl.pick  = 1'b1;
                list_ctrl.clear = 1'b1;
                n_seen          = '0;
            end
            ST_SET: begin
            end
            default: begin
            end
        endcase
    end

    tklm_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (list_ctrl),
        .i_value (i_logit),
        .o_pick  (pick)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SCAN;
            r_keep_count  <= '0;
            r_seen        <= '0;
            r_mask_pend   <= 1'b0;
            r_mask_active <= 1'b0;
            r_threshold   <= NEG_INF;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            if (i_cfg_wr_en) begin
                r_keep_count <= i_cfg_wr_data;
            end
            if (scan_acc && i_last) begin
                r_mask_pend <= (k_sat != '0) && (k_sat < seen_inc);
            end
            if (r_state == ST_SET) begin
                r_mask_active <= r_mask_pend;
                r_threshold   <= r_mask_pend ? pick : NEG_INF;
            end
            if (apply_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_acc && i_last) begin
            r_sel <= SEL_W'(k_sat - SEEN_W'(1));
        end
        if (apply_acc) begin
            r_logit_out <= (r_mask_active && (i_logit < r_threshold)) ? NEG_INF : i_logit;
            r_last_out  <= i_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_logit_out = r_logit_out;
    assign o_last_out  = r_last_out;

`ifndef SYNTHESIS
    a_finish_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> o_in_stall)
        else $error("input accepted while the threshold is being picked");

    a_last_starts_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_acc && i_last) |=> (r_state == ST_PICK))
        else $error("last scan request did not start the threshold pick");

    a_apply_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_acc |=> o_out_valid)
        else $error("apply request produced no result");

    a_unmasked_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply_acc && !r_mask_active) |=> (o_logit_out == $past(i_logit)))
        else $error("logit changed while masking is off");
`endif

endmodule

>>> test/top_k_logit_mask_unit_test.sv
module top_k_logit_mask_unit_test;

    import tklm_pkg::*;

    localparam t_logit LOGIT_MAX   = 32'sh7FFF_FFFF;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     RANDOM_REQS = 1100;
    localparam int     LONG_SCAN   = 70;
    localparam int     HOLD_CYCLES = 150;

    typedef enum {ROW_SCAN, ROW_APPLY, ROW_KEEP} t_plan_op;

    typedef struct {
        t_plan_op op;
        t_logit   value;
        logic     last;
        bit       typed;
        t_logit   want;
    } t_plan_row;

    typedef struct {
        t_logit logit;
        logic   last;
    } t_masked_item;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [KEEP_W-1:0]         i_cfg_wr_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_kind;
    logic signed [LOGIT_W-1:0] i_logit;
    logic                      i_last;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [LOGIT_W-1:0] o_logit_out;
    logic                      o_last_out;

    top_k_logit_mask_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_logit       (i_logit),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_logit_out   (o_logit_out),
        .o_last_out    (o_last_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the block's state.
    t_logit              top_list [MAX_KEEP];
    logic [SEEN_W-1:0]   scan_seen;
    t_logit              cut_level;
    bit                  masking_on;
    logic [KEEP_W-1:0]   keep_setting;

    t_masked_item pending_masked[$];
    t_plan_row    plan[$];

    int  cycle_count;
    int  n_errors;
    int  n_scan;
    int  n_apply;
    int  n_checked;
    int  n_keep_writes;
    bit  gaps_on;
    bit  pressure_run;

    function automatic void clear_top_list();
        for (int i = 0; i < MAX_KEEP; i++)
            top_list[i] = NEG_INF;
        scan_seen = '0;
    endfunction

    function automatic void scan_insert(t_logit value, logic last);
        int filled;
        int pos;
        int k;
        filled = (scan_seen < MAX_KEEP) ? int'(scan_seen) : MAX_KEEP;
        pos = 0;
        while (pos < filled && top_list[pos] >= value)
            pos++;
        if (pos < MAX_KEEP) begin
            for (int i = MAX_KEEP - 1; i > pos; i--)
                top_list[i] = top_list[i-1];
            top_list[pos] = value;
        end
        if (scan_seen != SEEN_MAX)
            scan_seen++;
        if (last) begin
            k = (keep_setting > MAX_KEEP) ? MAX_KEEP : int'(keep_setting);
            if (k == 0 || k >= scan_seen) begin
                masking_on = 1'b0;
                cut_level  = NEG_INF;
            end else begin
                masking_on = 1'b1;
                cut_level  = top_list[k-1];
            end
            clear_top_list();
        end
    endfunction

    function automatic t_logit masked_logit(t_logit value);
        return (masking_on && value < cut_level) ? NEG_INF : value;
    endfunction

    function automatic t_logit draw_logit();
        case ($urandom_range(0, 3))
            0: return t_logit'($urandom);
            1: return t_logit'($urandom_range(0, 15)) - 8;
            2: begin
                case ($urandom_range(0, 4))
                    0: return LOGIT_MAX;
                    1: return NEG_INF;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return t_logit'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic [KEEP_W-1:0] draw_keep();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return KEEP_W'($urandom_range(0, 8));
        else if (pick < 17)
            return KEEP_W'($urandom_range(9, MAX_KEEP));
        else
            return KEEP_W'($urandom_range(MAX_KEEP + 1, 127));
    endfunction

    function automatic int draw_length();
        return ($urandom_range(0, 6) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= 30)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_masked_result();
        t_masked_item want;
        if (pending_masked.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing outstanding", o_logit_out));
            return;
        end
        want = pending_masked.pop_front();
        n_checked++;
        if (o_logit_out !== want.logit)
            report_mismatch($sformatf("logit_out %h, expected %h", o_logit_out, want.logit));
        if (o_last_out !== want.last)
            report_mismatch($sformatf("last_out %b, expected %b", o_last_out, want.last));
    endtask

    // Drives one request and returns at the edge that accepts it. Valid stays
    // high afterwards so that back-to-back requests need no extra step.
    task automatic send_request(logic kind, t_logit value, logic last,
                                bit typed, t_logit want);
        int gap;
        t_masked_item item;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_logit    <= value;
        i_last     <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (kind == KIND_SCAN) begin
            n_scan++;
            scan_insert(value, last);
        end else begin
            n_apply++;
            item.logit = typed ? want : masked_logit(value);
            item.last  = last;
            pending_masked.push_back(item);
        end
    endtask

    // Lets the block drain, including the threshold pick after a final scan request.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_masked.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_keep(logic [KEEP_W-1:0] keep);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= keep;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        keep_setting = keep;
        n_keep_writes++;
    endtask

    task automatic add_row(t_plan_op op, t_logit value, logic last, bit typed, t_logit want);
        t_plan_row row;
        row.op    = op;
        row.value = value;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("** top_k_logit_mask_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_masked_result();
    end

    // Output side: random stall after each result, quiet stretches, and one long hold.
    initial begin : out_stall_driver
        int  wait_left;
        int  hold_left;
        int  taken;
        bit  held_once;
        bit  quiet;
        wait_left = 0;
        hold_left = 0;
        taken     = 0;
        held_once = 1'b0;
        quiet     = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                taken++;
                if (taken % 64 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                wait_left = quiet ? 0 : $urandom_range(0, 5);
            end
            if (pressure_run && !held_once) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_logit vec[$];
        int     base;
        int     len;
        int     rot;
        int     pick;
        t_logit value;
        bit     pressure_done;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_SCAN;
        i_logit       = '0;
        i_last        = 1'b0;
        pressure_run  = 1'b0;
        pressure_done = 1'b0;
        gaps_on       = 1'b1;
        cycle_count   = 0;
        n_errors      = 0;
        n_scan        = 0;
        n_apply       = 0;
        n_checked     = 0;
        n_keep_writes = 0;

        clear_top_list();
        cut_level    = NEG_INF;
        masking_on   = 1'b0;
        keep_setting = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Apply before any scan leaves everything unchanged.
        add_row(ROW_APPLY, LOGIT_MAX, 1'b0, 1'b1, LOGIT_MAX);
        add_row(ROW_APPLY, NEG_INF,   1'b0, 1'b1, NEG_INF);
        add_row(ROW_APPLY, 0,         1'b1, 1'b1, 0);
        // Keep two with both extremes in the vector.
        add_row(ROW_KEEP,  2,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  5,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  -3,        1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  LOGIT_MAX, 1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  NEG_INF,   1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  7,         1'b1, 1'b0, 0);
        add_row(ROW_APPLY, LOGIT_MAX, 1'b0, 1'b1, LOGIT_MAX);
        add_row(ROW_APPLY, 6,         1'b0, 1'b0, 0);
        add_row(ROW_APPLY, NEG_INF,   1'b0, 1'b1, NEG_INF);
        add_row(ROW_APPLY, 7,         1'b1, 1'b0, 0);
        // A write after the scan has closed must not move the threshold.
        add_row(ROW_KEEP,  0,         1'b0, 1'b0, 0);
        add_row(ROW_APPLY, 6,         1'b1, 1'b0, 0);
        // Keep zero turns masking off.
        add_row(ROW_SCAN,  9,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  9,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  1,         1'b1, 1'b0, 0);
        add_row(ROW_APPLY, 1,         1'b1, 1'b0, 0);
        // The largest setting saturates and exceeds the vector length.
        add_row(ROW_KEEP,  127,       1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  -5,        1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  4,         1'b1, 1'b0, 0);
        add_row(ROW_APPLY, -5,        1'b1, 1'b0, 0);
        // Duplicates at the cut are all kept.
        add_row(ROW_KEEP,  MAX_KEEP,  1'b0, 1'b0, 0);
        add_row(ROW_KEEP,  2,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  9,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  9,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  9,         1'b0, 1'b0, 0);
        add_row(ROW_SCAN,  1,         1'b1, 1'b0, 0);
        add_row(ROW_APPLY, 9,         1'b0, 1'b0, 0);
        add_row(ROW_APPLY, 8,         1'b1, 1'b0, 0);

        foreach (plan[r]) begin
            case (plan[r].op)
                ROW_KEEP: write_keep(plan[r].value[KEEP_W-1:0]);
                ROW_SCAN: send_request(KIND_SCAN, plan[r].value, plan[r].last, 1'b0, 0);
                default:  send_request(KIND_APPLY, plan[r].value, plan[r].last,
                                       plan[r].typed, plan[r].want);
            endcase
        end

        // One scan longer than the cell row, sent back to back.
        write_keep(5);
        gaps_on = 1'b0;
        for (int i = 0; i < LONG_SCAN; i++)
            send_request(KIND_SCAN, draw_logit(), i == LONG_SCAN - 1, 1'b0, 0);
        for (int i = 0; i < 16; i++)
            send_request(KIND_APPLY, draw_logit(), i == 15, 1'b0, 0);

        base = n_scan + n_apply;
        while (n_scan + n_apply - base < RANDOM_REQS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (!pressure_done && n_scan + n_apply - base >= RANDOM_REQS / 2) begin
                // Output held off while apply requests keep coming.
                pressure_done = 1'b1;
                gaps_on = 1'b0;
                pressure_run = 1'b1;
                for (int i = 0; i < 100; i++)
                    send_request(KIND_APPLY, draw_logit(), i == 99, 1'b0, 0);
                pressure_run = 1'b0;
            end else if (pick < 7) begin
                if ($urandom_range(0, 1))
                    write_keep(draw_keep());
                len = draw_length();
                vec.delete();
                for (int i = 0; i < len; i++)
                    vec.push_back(draw_logit());
                for (int i = 0; i < len; i++)
                    send_request(KIND_SCAN, vec[i], i == len - 1, 1'b0, 0);
                if ($urandom_range(0, 9) == 0)
                    write_keep(draw_keep());
                // Apply the same values rotated, some nudged by one across the cut.
                rot = $urandom_range(0, len - 1);
                for (int i = 0; i < len; i++) begin
                    value = vec[(i + rot) % len];
                    if ($urandom_range(0, 4) == 0)
                        value = value + t_logit'($urandom_range(0, 2)) - 1;
                    send_request(KIND_APPLY, value, i == len - 1, 1'b0, 0);
                end
            end else if (pick == 7) begin
                // Repeated apply pass against the last completed scan.
                len = draw_length();
                for (int i = 0; i < len; i++)
                    send_request(KIND_APPLY, draw_logit(), i == len - 1, 1'b0, 0);
            end else if (pick == 8) begin
                // Scan left open, then an apply pass in the middle of it.
                len = draw_length();
                for (int i = 0; i < len; i++)
                    send_request(KIND_SCAN, draw_logit(), 1'b0, 1'b0, 0);
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_request(KIND_APPLY, draw_logit(), i == len - 1, 1'b0, 0);
            end else begin
                // Noise: random kinds and last flags.
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_request(logic'($urandom_range(0, 1)), draw_logit(),
                                 logic'($urandom_range(0, 1)), 1'b0, 0);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d scan and %0d apply requests (one scan of %0d elements).",
                 n_scan, n_apply, LONG_SCAN);
        $display("Checked %0d results over %0d keep_count writes; output held off %0d cycles once.",
                 n_checked, n_keep_writes, HOLD_CYCLES);
        if (n_errors == 0 && pending_masked.size() == 0) begin
            $display("** top_k_logit_mask_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing.", n_errors, pending_masked.size());
            $display("** top_k_logit_mask_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tklm_pkg.sv
hdl/tklm_cell.sv
hdl/tklm_list.sv
hdl/top_k_logit_mask_unit.sv
test/top_k_logit_mask_unit_test.sv
